// ===== rtl/sgns_pkg.sv =====
`timescale 1ns / 1ps

package sgns_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_IN  = 2'd0,
        OP_LOAD_OUT = 2'd1,
        OP_TRAIN    = 2'd2,
        OP_READ     = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_DOT,
        ST_DRAIN,
        ST_IDX1,
        ST_IDX2,
        ST_IDX3,
        ST_LUT,
        ST_GRAD,
        ST_UPD,
        ST_UDRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [9:0]         word;
        logic [9:0]         target_word;
        logic               label;
        logic [2:0]         dim_index;
        logic signed [15:0] load_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] read_value;
        logic [15:0]        probability;
    } t_out;

    localparam logic [15:0] LR_RESET   = 16'd1638;
    localparam int          CLAMP_Q24  = 100663296;
    localparam int          UW         = 28;
    localparam int          IDX_SHIFT  = 26;
    localparam int          RECIP3     = 43691;
    localparam int          RECIP3_SH  = 17;
    localparam int          GW         = 35;
    localparam int          PW         = GW + 16;
    localparam int          TW         = PW - 32;

    localparam logic [63:0]        Q24_ONE    = 64'd1 << 24;
    localparam logic [63:0]        Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0]        EXP_M1_Q30 = 64'd395007542;
    localparam logic signed [63:0] X_MIN      = -64'sd100663296;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
        logic [63:0]        k;
        logic [63:0]        f;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        k    = a >> 24;
        f    = (a & 64'hFFFFFF) << 6;
        term = Q30_ONE;
        sum  = signed'(Q30_ONE);
        for (int n = 1; n <= 14; n++) begin
            term = udiv64((term * f) >> 30, 64'(n));
            if (n[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        r = (sum < 0) ? 64'd0 : unsigned'(sum);
        for (int j = 0; j < 8; j++) begin
            if (64'(j) < k) begin
                r = (r * EXP_M1_Q30 + (Q30_ONE >> 1)) >> 30;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] sig_entry(input int unsigned i, input int unsigned entries);
        logic [63:0]        step;
        logic [63:0]        e;
        logic [63:0]        d;
        logic [63:0]        p;
        logic signed [63:0] x;
        step = udiv64(64'd12 * Q24_ONE * 64'(i), 64'(entries));
        x    = X_MIN + signed'(step);
        if (x >= 0) begin
            e = exp_neg_q30(unsigned'(x));
            d = Q30_ONE + e;
            p = udiv64((64'd1 << 46) + (d >> 1), d);
        end else begin
            e = exp_neg_q30(unsigned'(-x));
            d = Q30_ONE + e;
            p = udiv64((e << 16) + (d >> 1), d);
        end
        return (p > 64'd65535) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// ===== rtl/skipgram_negative_sampling_update.sv =====
// Channel   Direction  Handshake            Payload
// in        input      i_in_valid/o_in_stall   t_in  (op, word, target_word, label, ...)
// out       output     o_out_valid/i_out_stall t_out (read_value, probability)
// cfg       input      i_cfg_valid/o_cfg_ready step size, 16 bits
//
// Train makes two passes over the rows through the single read port of each table, with
// clamp, index, sigmoid and gradient steps between them. One item is in work at a time;
// the output register holds a result while the next is taken. Reset is synchronous,
// active low; it clears control state and sets the step size to 1638. Table contents are not
// cleared: the user must write each entry before it is read; the block does not enforce it.
`timescale 1ns / 1ps

module skipgram_negative_sampling_update #(
    parameter int VOCAB_WORDS     = 1024,
    parameter int DIM             = 5,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sgns_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sgns_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import sgns_pkg::*;

    localparam int DEPTH = VOCAB_WORDS * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DIM + 1);
    localparam int ACCW  = 32 + $clog2(DIM);
    localparam int IW    = $clog2(SIGMOID_ENTRIES);
    localparam int MULW  = UW + $clog2(SIGMOID_ENTRIES + 1);
    localparam logic signed [ACCW-1:0] ACC_HI = ACCW'(CLAMP_Q24);
    localparam logic signed [ACCW-1:0] ACC_LO = -ACC_HI;

    logic signed [15:0] r_in_mem  [DEPTH];
    logic signed [15:0] r_out_mem [DEPTH];
    logic [15:0]        w_sig_lut [SIGMOID_ENTRIES];

    t_state r_state, n_state;

    logic [15:0]            r_lr;
    logic                   r_out_valid;
    t_out                   r_out_data;
    t_out                   r_res;
    logic [AW-1:0]          r_cbase, r_tbase;
    logic [CW-1:0]          r_cnt;
    logic                   r_label;
    logic                   r_rd_ok;
    logic signed [15:0]     r_in_rdata, r_out_rdata;
    logic                   r_d1_vld, r_d2_vld;
    logic signed [31:0]     r_d2_prod;
    logic signed [ACCW-1:0] r_acc;
    logic [UW-1:0]          r_u;
    logic [15:0]            r_v;
    logic [IW-1:0]          r_idx;
    logic [15:0]            r_prob;
    logic signed [GW-1:0]   r_grad;
    logic                   r_u1_vld, r_u2_vld;
    logic [AW-1:0]          r_u1_caddr, r_u1_taddr, r_u2_caddr, r_u2_taddr;
    logic signed [15:0]     r_u2_ci, r_u2_to;
    logic signed [PW-1:0]   r_u2_pc, r_u2_pt;

    logic               w_accept, w_out_free, w_last;
    logic               w_word_ok, w_tgt_ok, w_dim_ok;
    logic [AW-1:0]      w_addr, w_caddr, w_taddr;
    logic               w_dot_issue, w_upd_issue;
    logic               w_in_re, w_out_re, w_in_we, w_out_we;
    logic [AW-1:0]      w_in_raddr, w_in_waddr, w_out_waddr;
    logic signed [15:0] w_in_wdata, w_out_wdata;
    logic [MULW-1:0]    w_scaled;
    logic [31:0]        w_recip;
    logic [14:0]        w_q;
    logic signed [17:0] w_diff;
    logic signed [PW-1:0] w_tc, w_tt;
    logic signed [TW-1:0] w_term_c, w_term_t;

    for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_lut
        localparam logic [15:0] SIG_VAL = sig_entry(gi, SIGMOID_ENTRIES);
        assign w_sig_lut[gi] = SIG_VAL;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = (r_cnt == CW'(DIM - 1));
    assign w_word_ok  = 32'(i_in_data.word) < 32'(VOCAB_WORDS);
    assign w_tgt_ok   = 32'(i_in_data.target_word) < 32'(VOCAB_WORDS);
    assign w_dim_ok   = 32'(i_in_data.dim_index) < 32'(DIM);
    assign w_addr     = AW'(32'(i_in_data.word) * 32'(DIM) + 32'(i_in_data.dim_index));
    assign w_caddr    = r_cbase + AW'(r_cnt);
    assign w_taddr    = r_tbase + AW'(r_cnt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_data.op)
                        OP_LOAD_IN, OP_LOAD_OUT: n_state = ST_DONE;
                        OP_READ:                 n_state = ST_RDWAIT;
                        OP_TRAIN:                n_state = (w_word_ok && w_tgt_ok) ? ST_DOT
                                                                                   : ST_DONE;
                        default:                 n_state = ST_DONE;
                    endcase
                end
            end
            ST_RDWAIT: n_state = ST_DONE;
            ST_DOT:    n_state = w_last ? ST_DRAIN : ST_DOT;
            ST_DRAIN:  n_state = (!r_d1_vld && !r_d2_vld) ? ST_IDX1 : ST_DRAIN;
            ST_IDX1:   n_state = ST_IDX2;
            ST_IDX2:   n_state = ST_IDX3;
            ST_IDX3:   n_state = ST_LUT;
            ST_LUT:    n_state = ST_GRAD;
            ST_GRAD:   n_state = ST_UPD;
            ST_UPD:    n_state = w_last ? ST_UDRAIN : ST_UPD;
            ST_UDRAIN: n_state = (!r_u1_vld && !r_u2_vld) ? ST_DONE : ST_UDRAIN;
            ST_DONE:   n_state = w_out_free ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        w_dot_issue = (r_state == ST_DOT);
        w_upd_issue = (r_state == ST_UPD);
        w_out_re    = w_dot_issue || w_upd_issue;
        w_in_re     = w_out_re;
        w_in_raddr  = w_caddr;
        if (r_state == ST_IDLE) begin
            w_in_re    = w_accept && (i_in_data.op == OP_READ);
            w_in_raddr = w_addr;
        end
        w_in_we     = r_u2_vld;
        w_in_waddr  = r_u2_caddr;
        w_in_wdata  = sat16(20'(r_u2_ci) + 20'(w_term_c));
        w_out_we    = r_u2_vld;
        w_out_waddr = r_u2_taddr;
        w_out_wdata = sat16(20'(r_u2_to) + 20'(w_term_t));
        if (w_accept && w_word_ok && w_dim_ok) begin
            if (i_in_data.op == OP_LOAD_IN) begin
                w_in_we    = 1'b1;
                w_in_waddr = w_addr;
                w_in_wdata = i_in_data.load_value;
            end
            if (i_in_data.op == OP_LOAD_OUT) begin
                w_out_we    = 1'b1;
                w_out_waddr = w_addr;
                w_out_wdata = i_in_data.load_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_we) begin
            r_in_mem[w_in_waddr] <= w_in_wdata;
        end
        if (w_in_re) begin
            r_in_rdata <= r_in_mem[w_in_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_we) begin
            r_out_mem[w_out_waddr] <= w_out_wdata;
        end
        if (w_out_re) begin
            r_out_rdata <= r_out_mem[w_taddr];
        end
    end

    assign w_scaled = MULW'(r_u) * MULW'(SIGMOID_ENTRIES);
    assign w_recip  = 32'(r_v) * 32'(RECIP3);
    assign w_q      = w_recip[31:RECIP3_SH];
    assign w_diff   = (r_label ? 18'sd65536 : 18'sd0) - signed'({2'b00, r_prob});
    assign w_tc     = r_u2_pc + PW'(64'd1 << 31);
    assign w_tt     = r_u2_pt + PW'(64'd1 << 31);
    assign w_term_c = w_tc[PW-1:32];
    assign w_term_t = w_tt[PW-1:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lr        <= LR_RESET;
            r_out_valid <= 1'b0;
            r_d1_vld    <= 1'b0;
            r_d2_vld    <= 1'b0;
            r_u1_vld    <= 1'b0;
            r_u2_vld    <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state  <= n_state;
            r_d1_vld <= w_dot_issue;
            r_d2_vld <= r_d1_vld;
            r_u1_vld <= w_upd_issue;
            r_u2_vld <= r_u1_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lr <= i_cfg_data;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_dot_issue || w_upd_issue) begin
                r_cnt <= w_last ? '0 : r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= r_res;
        end
        if (w_accept) begin
            r_res   <= '0;
            r_label <= i_in_data.label;
            r_rd_ok <= w_word_ok && w_dim_ok;
            r_acc   <= '0;
            r_cbase <= AW'(32'(i_in_data.word) * 32'(DIM));
            r_tbase <= AW'(32'(i_in_data.target_word) * 32'(DIM));
        end else if (r_d2_vld) begin
            r_acc <= r_acc + ACCW'(r_d2_prod);
        end
        if (r_state == ST_RDWAIT && r_rd_ok) begin
            r_res.read_value <= r_in_rdata;
        end
        r_d2_prod <= 32'(r_in_rdata) * 32'(r_out_rdata);
        if (r_acc > ACC_HI) begin
            r_u <= UW'(2 * CLAMP_Q24);
        end else if (r_acc < ACC_LO) begin
            r_u <= '0;
        end else begin
            r_u <= UW'(r_acc + ACC_HI);
        end
        r_v   <= 16'(w_scaled >> IDX_SHIFT);
        r_idx <= (w_q >= 15'(SIGMOID_ENTRIES)) ? IW'(SIGMOID_ENTRIES - 1) : IW'(w_q);
        if (r_state == ST_LUT) begin
            r_prob            <= w_sig_lut[r_idx];
            r_res.probability <= w_sig_lut[r_idx];
        end
        r_grad     <= GW'(signed'({1'b0, r_lr})) * GW'(w_diff);
        r_u1_caddr <= w_caddr;
        r_u1_taddr <= w_taddr;
        r_u2_caddr <= r_u1_caddr;
        r_u2_taddr <= r_u1_taddr;
        r_u2_ci    <= r_in_rdata;
        r_u2_to    <= r_out_rdata;
        r_u2_pc    <= PW'(r_grad) * PW'(r_out_rdata);
        r_u2_pt    <= PW'(r_grad) * PW'(r_in_rdata);
    end

    a_write_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u2_vld |-> (r_state == ST_UPD || r_state == ST_UDRAIN))
        else $error("table write-back outside update phase");

    a_no_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d1_vld || r_d2_vld || r_u1_vld || r_u2_vld) |-> o_in_stall)
        else $error("input transfer while row pipeline busy");

    a_drain_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDX1) |-> (!r_d1_vld && !r_d2_vld))
        else $error("dot product used before accumulation finished");

    a_result_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished result not presented");

endmodule
